### rtl/qtg_pkg.sv
// Shared types and constants for the quintic trajectory generator.
// No dependencies.
package qtg_pkg;

    // APB register byte addresses.
    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_PERIOD   = 3'd4;

    // Queue entry: one classified beat handed from front to back.
    typedef struct packed {
        logic        is_tick;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] z_pos;
        logic [15:0] tilt_req;
    } qtg_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAN,     // CORDIC on (x, y) for pan
        ST_SQRT,    // bit-serial root of (x^2+y^2)<<16
        ST_TILT,    // CORDIC on (r, z) for tilt
        ST_CNT,     // N = duration / period + 1 by restoring divide
        ST_SDIV,    // s = index*period<<16 / duration
        ST_POLY,    // Horner steps of the blend
        ST_SCALE,   // final * b for each axis
        ST_OUT      // result waiting in output register
    } qtg_state_t;

    localparam logic [17:0] PI_UNITS = 18'd205887;

    // atan(2^-i) in units of 2^-16 rad.
    function automatic logic [15:0] atan_lut(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0: v = 16'd51472;
            4'd1: v = 16'd30386;
            4'd2: v = 16'd16055;
            4'd3: v = 16'd8150;
            4'd4: v = 16'd4091;
            4'd5: v = 16'd2047;
            4'd6: v = 16'd1024;
            4'd7: v = 16'd512;
            4'd8: v = 16'd256;
            4'd9: v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

### rtl/qtg_front.sv
// Front end: accepts input beats and pushes them into a two-entry queue.
// Depends on qtg_pkg.
module qtg_front import qtg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_x_pos,
    input  logic [15:0] s_y_pos,
    input  logic [15:0] s_z_pos,
    input  logic [15:0] s_tilt_req,
    output logic        q_valid,
    input  logic        q_pop,
    output qtg_cmd_t    q_head
);
    qtg_cmd_t    mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    qtg_cmd_t    cmd;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = mem_reg[rp_reg];

    always_comb begin
        cmd.is_tick  = s_mode;
        cmd.x_pos    = s_x_pos;
        cmd.y_pos    = s_y_pos;
        cmd.z_pos    = s_z_pos;
        cmd.tilt_req = s_tilt_req;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

### rtl/qtg_back.sv
// Back end: sequencer with shared CORDIC, root, divider and multiplier.
// Depends on qtg_pkg.
module qtg_back import qtg_pkg::*; #(
    parameter int SAMPLE_CAP = 100,
    parameter int IDX_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_pop,
    input  qtg_cmd_t          q_head,
    input  logic [15:0]       duration_ms,
    input  logic [15:0]       sample_period_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_pan_out,
    output logic [15:0]       m_tilt_out,
    output logic [15:0]       m_roll_out,
    output logic [IDX_W-1:0]  m_sample_index,
    output logic              m_last_sample
);
    localparam int CW  = 32;   // CORDIC datapath width
    localparam int NW  = $clog2(SAMPLE_CAP + 1);
    localparam logic [NW-1:0] MAXN = NW'(SAMPLE_CAP);

    qtg_state_t st_reg, st_next;

    qtg_cmd_t             cmd_reg, cmd_next;   // target being worked on
    logic signed [CW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [19:0]   acc_reg, acc_next;
    logic [5:0]           step_reg, step_next;
    logic [47:0]          rem_reg, rem_next;   // root / divide remainder
    logic [47:0]          rad_reg, rad_next;   // root radicand or dividend
    logic [23:0]          root_reg, root_next;
    logic [15:0]          fa_reg [3];
    logic [15:0]          fa_next [3];
    logic [NW-1:0]        idx_reg, idx_next, tot_reg, tot_next;
    logic [17:0]          s_reg, s_next;
    logic signed [35:0]   t_reg, t_next;
    logic [1:0]           ax_reg, ax_next;
    logic [15:0]          o_reg [3];
    logic [15:0]          o_next [3];

    // CORDIC step
    logic signed [CW-1:0] dx, dy;
    logic signed [19:0]   lut;
    // restoring root step
    logic [47:0]          r_try, r_rem2;
    // divider step
    logic [48:0]          d_rem2;
    // multiplier
    logic signed [23:0]   mul_a, mul_b;
    logic signed [47:0]   mul_p;
    logic signed [47:0]   mul_r;
    logic signed [16:0]   tilt_s;
    logic signed [16:0]   sat_v;
    logic                 fin;

    assign dx  = cy_reg >>> step_reg[3:0];
    assign dy  = cx_reg >>> step_reg[3:0];
    assign lut = 20'(atan_lut(step_reg[3:0]));
    assign mul_p = mul_a * mul_b;
    assign mul_r = (mul_p + 48'sd32768) >>> 16;
    assign q_pop = (st_reg == ST_IDLE) && q_valid;
    assign m_valid = (st_reg == ST_OUT);
    assign m_pan_out  = o_reg[0];
    assign m_tilt_out = o_reg[1];
    assign m_roll_out = o_reg[2];
    assign m_sample_index = IDX_W'(idx_reg - NW'(1));
    assign m_last_sample  = (idx_reg == tot_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            idx_reg <= '0;
            tot_reg <= '0;
            fa_reg[0] <= '0; fa_reg[1] <= '0; fa_reg[2] <= '0;
        end else begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            tot_reg <= tot_next;
            fa_reg  <= fa_next;
        end
        cmd_reg <= cmd_next;
        cx_reg <= cx_next; cy_reg <= cy_next; acc_reg <= acc_next;
        step_reg <= step_next; rem_reg <= rem_next; rad_reg <= rad_next;
        root_reg <= root_next; s_reg <= s_next; t_reg <= t_next;
        ax_reg <= ax_next; o_reg <= o_next;
    end

    always_comb begin
        st_next = st_reg;
        cmd_next = cmd_reg;
        cx_next = cx_reg; cy_next = cy_reg; acc_next = acc_reg;
        step_next = step_reg; rem_next = rem_reg; rad_next = rad_reg;
        root_next = root_reg; fa_next = fa_reg; idx_next = idx_reg;
        tot_next = tot_reg; s_next = s_reg; t_next = t_reg;
        ax_next = ax_reg; o_next = o_reg;
        mul_a = '0; mul_b = '0;
        r_try = '0; r_rem2 = '0; d_rem2 = '0;
        tilt_s = '0; sat_v = '0; fin = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_head;
                    step_next = '0;
                    if (!q_head.is_tick) begin
                        // roll target: saturated negate
                        tilt_s = 17'sd0 - 17'(signed'(q_head.tilt_req));
                        fa_next[2] = (tilt_s > 17'sd32767) ? 16'h7fff : tilt_s[15:0];
                        // prerotate by pi for negative x
                        cx_next = CW'(signed'(q_head.x_pos)) <<< 8;
                        cy_next = CW'(signed'(q_head.y_pos)) <<< 8;
                        acc_next = '0;
                        if (q_head.x_pos[15]) begin
                            cx_next = -(CW'(signed'(q_head.x_pos)) <<< 8);
                            cy_next = -(CW'(signed'(q_head.y_pos)) <<< 8);
                            acc_next = q_head.y_pos[15] ? -20'(PI_UNITS) : 20'(PI_UNITS);
                        end
                        st_next = ST_PAN;
                    end else if (idx_reg < tot_reg) begin
                        rad_next = 48'(idx_reg) * 48'(sample_period_ms) << 16;
                        rem_next = '0;
                        st_next = (duration_ms == '0) ? ST_POLY : ST_SDIV;
                        if (duration_ms == '0) begin
                            s_next = '0;
                            t_next = -36'sd983040;
                        end
                    end
                end
            end
            ST_PAN, ST_TILT: begin
                if (cy_reg > 0) begin
                    cx_next = cx_reg + dx; cy_next = cy_reg - dy;
                    acc_next = acc_reg + lut;
                end else begin
                    cx_next = cx_reg - dx; cy_next = cy_reg + dy;
                    acc_next = acc_reg - lut;
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd15) begin
                    step_next = '0;
                    fin = 1'b1;
                end
                if (fin && st_reg == ST_PAN) begin
                    fa_next[0] = (cmd_reg.x_pos == '0 && cmd_reg.y_pos == '0) ? '0 :
                                 16'(-((acc_next + 20'sd4) >>> 3));
                    rad_next = (48'(32'(signed'(cmd_reg.x_pos) * signed'(cmd_reg.x_pos)))
                              + 48'(32'(signed'(cmd_reg.y_pos) * signed'(cmd_reg.y_pos))))
                              << 16;
                    rem_next = '0; root_next = '0;
                    st_next = ST_SQRT;
                end else if (fin) begin
                    fa_next[1] = (cmd_reg.x_pos == '0 && cmd_reg.y_pos == '0 &&
                                  cmd_reg.z_pos == '0) ? '0 :
                                 16'(-((acc_next + 20'sd4) >>> 3));
                    rad_next = 48'(duration_ms) << 32;
                    rem_next = '0;
                    st_next = ST_CNT;
                end
            end
            ST_SQRT: begin
                // two radicand bits per cycle
                r_rem2 = {rem_reg[45:0], rad_reg[47:46]};
                r_try  = {22'd0, root_reg, 2'b01};
                rad_next = rad_reg << 2;
                if (r_rem2 >= r_try) begin
                    rem_next = r_rem2 - r_try;
                    root_next = {root_reg[22:0], 1'b1};
                end else begin
                    rem_next = r_rem2;
                    root_next = {root_reg[22:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd23) begin
                    step_next = '0;
                    cx_next = CW'(root_next);
                    cy_next = CW'(signed'(cmd_reg.z_pos)) <<< 8;
                    acc_next = '0;
                    st_next = ST_TILT;
                end
            end
            ST_CNT, ST_SDIV: begin
                // restoring divide, one quotient bit per cycle
                d_rem2 = {rem_reg, rad_reg[47]};
                if (st_reg == ST_CNT) begin
                    rad_next = {rad_reg[46:0], 1'b0};
                    if (d_rem2 >= 49'(sample_period_ms) && sample_period_ms != '0) begin
                        rem_next = 48'(d_rem2 - 49'(sample_period_ms));
                        rad_next[0] = 1'b1;
                    end else begin
                        rem_next = d_rem2[47:0];
                    end
                end else begin
                    rad_next = {rad_reg[46:0], 1'b0};
                    if (d_rem2 >= 49'(duration_ms)) begin
                        rem_next = 48'(d_rem2 - 49'(duration_ms));
                        rad_next[0] = 1'b1;
                    end else begin
                        rem_next = d_rem2[47:0];
                    end
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd47) begin
                    step_next = '0;
                    if (st_reg == ST_CNT) begin
                        // dividend was duration<<32, so the integer part is the top 16 bits
                        if (sample_period_ms == '0 || rad_next[47:32] >= 16'(SAMPLE_CAP))
                            tot_next = MAXN;
                        else
                            tot_next = NW'(rad_next[47:32] + 16'd1);
                        idx_next = '0;
                        st_next = ST_IDLE;
                    end else begin
                        s_next = (rad_next > 48'd65536) ? 18'd65536 : rad_next[17:0];
                        t_next = 36'(6 * 36'(s_next)) - 36'sd983040;
                        st_next = ST_POLY;
                    end
                end
            end
            ST_POLY: begin
                mul_a = t_reg[23:0];
                mul_b = 24'(s_reg);
                t_next = 36'(mul_r);
                if (step_reg == 6'd0)
                    t_next = 36'(mul_r) + 36'sd655360;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd3) begin
                    step_next = '0;
                    ax_next = '0;
                    st_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mul_a = 24'(signed'(fa_reg[ax_reg]));
                mul_b = t_reg[23:0];
                sat_v = (mul_r > 48'sd32767) ? 17'sd32767 :
                        (mul_r < -48'sd32768) ? -17'sd32768 : 17'(mul_r);
                o_next[ax_reg] = sat_v[15:0];
                ax_next = ax_reg + 2'd1;
                if (ax_reg == 2'd2) begin
                    idx_next = idx_reg + NW'(1);
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end
endmodule

### rtl/quintic_trajectory_generator.sv
// Top level of the quintic trajectory generator: APB registers, front queue,
// back sequencer. Depends on qtg_pkg, qtg_front, qtg_back.
//
// Usage: s_* beats carry a target (s_mode = 0) or a sample tick (s_mode = 1).
// A target computes pan/tilt/roll final angles (CORDIC atan2, root, count
// divide) and produces no result. A tick while a move is active raises
// m_valid after its beat is taken (queue pop, s divide, 4 Horner multiplies,
// 3 scaling multiplies; the s divide is skipped when duration_ms is zero);
// ticks past the move give nothing. One item is in work at a time, while
// a two-entry queue keeps accepting beats.
// m_valid holds with stable payload until m_ready; the back end waits there,
// and once the queue holds two beats s_ready drops.
// Reset (aresetn low, synchronous) clears the queue, the move (no samples)
// and final angles; duration_ms = 2000, sample_period_ms = 40.
// Registers: 0x0 duration_ms, 0x4 sample_period_ms; write only while idle.
module quintic_trajectory_generator import qtg_pkg::*; #(
    parameter int SAMPLE_CAP = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_x_pos,
    input  logic [15:0] s_y_pos,
    input  logic [15:0] s_z_pos,
    input  logic [15:0] s_tilt_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pan_out,
    output logic [15:0] m_tilt_out,
    output logic [15:0] m_roll_out,
    output logic [6:0]  m_sample_index,
    output logic        m_last_sample
);
    logic [15:0] dur_reg, per_reg;
    logic        q_valid, q_pop;
    qtg_cmd_t    q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] ? {16'd0, per_reg} : {16'd0, dur_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg <= 16'd2000;
            per_reg <= 16'd40;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_DURATION) dur_reg <= pwdata[15:0];
            if (paddr == REG_PERIOD) per_reg <= pwdata[15:0];
        end
    end

    qtg_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_x_pos, .s_y_pos,
        .s_z_pos, .s_tilt_req, .q_valid, .q_pop, .q_head
    );

    qtg_back #(.SAMPLE_CAP(SAMPLE_CAP), .IDX_W(7)) u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_head,
        .duration_ms(dur_reg), .sample_period_ms(per_reg),
        .m_valid, .m_ready, .m_pan_out, .m_tilt_out, .m_roll_out,
        .m_sample_index, .m_last_sample
    );
endmodule

### rtl/qtg_checker.sv
// Port-level checks for the quintic trajectory generator.
// Depends on quintic_trajectory_generator (bound below).
module qtg_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_pan_out,
    input logic        pready
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pan_out)) else $error("m hold");
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
    a_no_b2b: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid) else $error("result repeated");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid) else $error("reset");
endmodule

bind quintic_trajectory_generator qtg_assert u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_pan_out, .pready
);
